@@ src/rthsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rthsv_pkg: shared types and constants for the rgb to hsv converter
// channel and hue widths, pipeline depth, sector codes and stage payloads
// ----------------------------------------------------------------------------
package rthsv_pkg;

  localparam int CHAN_W   = 8;
  localparam int HUE_FB   = 8;
  localparam int HUE_W    = HUE_FB + 3;
  localparam int QUO_W    = (HUE_FB + 1 > CHAN_W) ? HUE_FB + 1 : CHAN_W;
  localparam int NUM_W    = CHAN_W + QUO_W;
  localparam int PIPE_LAT = QUO_W + 3;

  localparam logic [HUE_W-1:0] HUE_TWO  = HUE_W'(2 << HUE_FB);
  localparam logic [HUE_W-1:0] HUE_FOUR = HUE_W'(4 << HUE_FB);
  localparam logic [HUE_W-1:0] HUE_SIX  = HUE_W'(6 << HUE_FB);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hi;
    sector_t           sector;
    logic              neg;
    logic              grey;
  } side_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  acc;
    logic [CHAN_W-1:0] div;
  } div_lane_t;

  typedef struct packed {
    logic [QUO_W-1:0] hue_quo;
    logic             hue_rnz;
    logic [QUO_W-1:0] sat_quo;
    side_t            side;
  } div_res_t;

endpackage

@@ src/rthsv_front.sv @@
// ----------------------------------------------------------------------------
// rthsv_front: two-stage front end
// picks largest and smallest channel and the sector, then forms chroma,
// the signed channel difference and the dividend of both divisions
// ----------------------------------------------------------------------------
module rthsv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [rthsv_pkg::CHAN_W-1:0] red,
  input  logic [rthsv_pkg::CHAN_W-1:0] green,
  input  logic [rthsv_pkg::CHAN_W-1:0] blue,
  output logic                         out_vld,
  output rthsv_pkg::div_lane_t         hue_lane,
  output rthsv_pkg::div_lane_t         sat_lane,
  output rthsv_pkg::side_t             side
);
  import rthsv_pkg::*;

  logic              a_vld_r;
  logic [CHAN_W-1:0] a_hi_r, a_lo_r, a_opa_r, a_opb_r;
  sector_t           a_sec_r;
  logic [CHAN_W-1:0] hi_nxt, lo_nxt, opa_nxt, opb_nxt;
  sector_t           sec_nxt;

  logic              b_vld_r;
  div_lane_t         b_hue_r, b_sat_r;
  side_t             b_side_r;
  div_lane_t         hue_nxt, sat_nxt;
  side_t             side_nxt;
  logic [CHAN_W-1:0] chroma, mag;
  logic              neg;
  logic [NUM_W-1:0]  hue_num, sat_num;

  // max with red then green winning ties, min, sector operands
  always_comb begin
    if (red >= green && red >= blue) begin
      hi_nxt  = red;
      sec_nxt = SEC_RED;
      opa_nxt = green;
      opb_nxt = blue;
    end else if (green >= blue) begin
      hi_nxt  = green;
      sec_nxt = SEC_GREEN;
      opa_nxt = blue;
      opb_nxt = red;
    end else begin
      hi_nxt  = blue;
      sec_nxt = SEC_BLUE;
      opa_nxt = red;
      opb_nxt = green;
    end
    lo_nxt = red;
    if (green < lo_nxt) lo_nxt = green;
    if (blue < lo_nxt) lo_nxt = blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_hi_r  <= hi_nxt;
    a_lo_r  <= lo_nxt;
    a_opa_r <= opa_nxt;
    a_opb_r <= opb_nxt;
    a_sec_r <= sec_nxt;
  end

  always_comb begin
    chroma  = a_hi_r - a_lo_r;
    neg     = a_opa_r < a_opb_r;
    mag     = neg ? (a_opb_r - a_opa_r) : (a_opa_r - a_opb_r);
    hue_num = NUM_W'(mag) << HUE_FB;
    sat_num = (NUM_W'(chroma) << CHAN_W) - NUM_W'(chroma);

    hue_nxt.rem = hue_num[NUM_W-1:QUO_W];
    hue_nxt.acc = hue_num[QUO_W-1:0];
    hue_nxt.div = chroma;
    sat_nxt.rem = sat_num[NUM_W-1:QUO_W];
    sat_nxt.acc = sat_num[QUO_W-1:0];
    sat_nxt.div = a_hi_r;

    side_nxt.hi     = a_hi_r;
    side_nxt.sector = a_sec_r;
    side_nxt.neg    = neg;
    side_nxt.grey   = (chroma == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_hue_r  <= hue_nxt;
    b_sat_r  <= sat_nxt;
    b_side_r <= side_nxt;
  end

  assign out_vld  = b_vld_r;
  assign hue_lane = b_hue_r;
  assign sat_lane = b_sat_r;
  assign side     = b_side_r;

endmodule

@@ src/rthsv_divpipe.sv @@
// ----------------------------------------------------------------------------
// rthsv_divpipe: pipelined restoring divider, two lanes
// one quotient bit per stage for the hue fraction and the saturation
// ----------------------------------------------------------------------------
module rthsv_divpipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  rthsv_pkg::div_lane_t hue_lane,
  input  rthsv_pkg::div_lane_t sat_lane,
  input  rthsv_pkg::side_t     side,
  output logic                 out_vld,
  output rthsv_pkg::div_res_t  res
);
  import rthsv_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t l);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] d;
    div_lane_t       o;
    t = {l.rem, l.acc[QUO_W-1]};
    d = {1'b0, l.div};
    o = l;
    if (t >= d) begin
      o.rem = CHAN_W'(t - d);
      o.acc = {l.acc[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[CHAN_W-1:0];
      o.acc = {l.acc[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic      vld_r  [QUO_W];
  div_lane_t hue_r  [QUO_W];
  div_lane_t sat_r  [QUO_W];
  side_t     side_r [QUO_W];

  genvar s;
  generate
    for (s = 0; s < QUO_W; s++) begin : g_stage
      logic      vld_prev;
      div_lane_t hue_prev, sat_prev, hue_nxt, sat_nxt;
      side_t     side_prev;

      if (s == 0) begin : g_first
        assign vld_prev  = in_vld;
        assign hue_prev  = hue_lane;
        assign sat_prev  = sat_lane;
        assign side_prev = side;
      end else begin : g_next
        assign vld_prev  = vld_r[s-1];
        assign hue_prev  = hue_r[s-1];
        assign sat_prev  = sat_r[s-1];
        assign side_prev = side_r[s-1];
      end

      assign hue_nxt = div_step(hue_prev);
      assign sat_nxt = div_step(sat_prev);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= vld_prev;
        end
        hue_r[s]  <= hue_nxt;
        sat_r[s]  <= sat_nxt;
        side_r[s] <= side_prev;
      end
    end
  endgenerate

  assign out_vld     = vld_r[QUO_W-1];
  assign res.hue_quo = hue_r[QUO_W-1].acc;
  assign res.hue_rnz = (hue_r[QUO_W-1].rem != '0);
  assign res.sat_quo = sat_r[QUO_W-1].acc;
  assign res.side    = side_r[QUO_W-1];

endmodule

@@ src/rthsv_back.sv @@
// ----------------------------------------------------------------------------
// rthsv_back: result stage
// floors the signed fraction, adds the sector base with wrap, applies the
// grey and black special cases and registers the result
// ----------------------------------------------------------------------------
module rthsv_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  rthsv_pkg::div_res_t          res,
  output logic                         out_vld,
  output logic [rthsv_pkg::HUE_W-1:0]  hue,
  output logic [rthsv_pkg::CHAN_W-1:0] saturation,
  output logic [rthsv_pkg::CHAN_W-1:0] brightness
);
  import rthsv_pkg::*;

  logic              vld_r;
  logic [HUE_W-1:0]  hue_r, hue_nxt, base;
  logic [CHAN_W-1:0] sat_r, sat_nxt, bri_r;
  logic [QUO_W:0]    frac_full;
  logic [HUE_W-1:0]  frac;

  always_comb begin
    // negative fraction rounds away from zero so the hue floors
    frac_full = {1'b0, res.hue_quo} + (QUO_W+1)'(res.side.neg & res.hue_rnz);
    frac      = HUE_W'(frac_full[HUE_FB:0]);
    case (res.side.sector)
      SEC_RED:   base = res.side.neg ? HUE_SIX : '0;
      SEC_GREEN: base = HUE_TWO;
      SEC_BLUE:  base = HUE_FOUR;
      default:   base = '0;
    endcase
    if (res.side.grey) begin
      hue_nxt = '0;
    end else if (res.side.neg) begin
      hue_nxt = base - frac;
    end else begin
      hue_nxt = base + frac;
    end
    sat_nxt = (res.side.hi == '0) ? '0 : res.sat_quo[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    bri_r <= res.side.hi;
  end

  assign out_vld    = vld_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bri_r;

endmodule

@@ src/rgb_to_hsv_convert.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert: fixed-point rgb to hsv pixel converter
// Takes one pixel per clock and returns hue (256 steps per sector, one turn
// is 1536), saturation floor(255*chroma/value) and value (largest channel).
// busy is always low: a request is taken on every cycle start is high. Each
// result appears for one cycle with out_valid high, after passing through the
// front end, the two long-division pipelines, which resolve one quotient bit
// per stage, and the result stage. There is no backpressure, so the receiver
// must take every result as it comes.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rthsv_pkg::CHAN_W-1:0] in_red,
  input  logic [rthsv_pkg::CHAN_W-1:0] in_green,
  input  logic [rthsv_pkg::CHAN_W-1:0] in_blue,
  output logic                         out_valid,
  output logic [rthsv_pkg::HUE_W-1:0]  out_hue,
  output logic [rthsv_pkg::CHAN_W-1:0] out_saturation,
  output logic [rthsv_pkg::CHAN_W-1:0] out_brightness
);
  import rthsv_pkg::*;

  logic      fe_vld, dv_vld;
  div_lane_t fe_hue, fe_sat;
  side_t     fe_side;
  div_res_t  dv_res;

  assign busy = 1'b0;

  rthsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .out_vld  (fe_vld),
    .hue_lane (fe_hue),
    .sat_lane (fe_sat),
    .side     (fe_side)
  );

  rthsv_divpipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fe_vld),
    .hue_lane (fe_hue),
    .sat_lane (fe_sat),
    .side     (fe_side),
    .out_vld  (dv_vld),
    .res      (dv_res)
  );

  rthsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (dv_vld),
    .res        (dv_res),
    .out_vld    (out_valid),
    .hue        (out_hue),
    .saturation (out_saturation),
    .brightness (out_brightness)
  );

`ifndef NO_ASSERTIONS
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##PIPE_LAT out_valid)
    else $error("request produced no result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without request");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_SIX)
    else $error("hue beyond one turn");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
